@@ sv/sha_pkg.sv @@
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        digest_last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ sv/sha_round.sv @@
module sha_round (
    input  logic [255:0] v,
    input  logic [31:0]  k,
    input  logic [31:0]  w,
    output logic [255:0] v_new
);
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = v;
        big1 = sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25);
        ch   = (e & f) ^ (~e & g);
        big0 = sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22);
        maj  = (a & b) ^ (a & c) ^ (b & c);
        t1   = h + big1 + ch + k + w;
        t2   = big0 + maj;
        v_new = {t1 + t2, a, b, c, d + t1, e, f, g};
    end
endmodule

@@ sv/sha256_byte_stream_hasher_unit.sv @@
// streaming sha-256: one byte per input word, the last word pads the message and
// returns the digest as four big-endian 64-bit words. a byte that does not close a
// block leaves the unit idle for the next word. a byte that fills a 64-byte
// block holds the input through acceptance, a load state streaming the block memory
// one 32-bit word a cycle into the schedule, 64 rounds of one shared round unit, a
// fold and a wrap-up state. a last word runs one or two further compressions for
// padding, then holds the input while the four digest words leave, at best one
// a cycle. the block lives in a 16x32 memory with a registered read, written
// one byte lane at a time.
module sha256_byte_stream_hasher_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sha_pkg::out_word_t  out_data
);
    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    sha_pkg::state_t state_reg, state_next;
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [255:0] hash_reg;
    logic [255:0] v_reg;
    logic [511:0] sched_reg;
    logic [6:0]   cnt_reg;
    logic         fin_reg;
    logic         second_reg;
    logic         tail_reg;
    logic [1:0]   oidx_reg;
    logic [63:0]  total_reg;

    logic [255:0] v_new;
    logic [31:0]  w_cur, w_next, x, y, s0, s1, pad_word;
    logic         wr_en;
    logic [3:0]   wr_addr, rd_addr;
    logic [3:0]   wr_be;
    logic [31:0]  wr_data;

    assign w_cur = sched_reg[511:480];
    assign x     = sched_reg[479:448];
    assign y     = sched_reg[63:32];
    assign s0    = sha_pkg::rotr(x, 7) ^ sha_pkg::rotr(x, 18) ^ (x >> 3);
    assign s1    = sha_pkg::rotr(y, 17) ^ sha_pkg::rotr(y, 19) ^ (y >> 10);
    assign w_next = w_cur + s0 + sched_reg[223:192] + s1;

    sha_round u_round (
        .v     (v_reg),
        .k     (sha_pkg::ROUND_K[cnt_reg[5:0]]),
        .w     (w_cur),
        .v_new (v_new)
    );

    // pad view of a memory word: 0x80 then zero past the fill, all zero on pass two
    always_comb
    begin
        logic [5:0] bidx;
        pad_word = rd_data_reg;
        for (int j = 0; j < 4; j++)
        begin
            bidx = {cnt_reg[3:0] - 4'd1, 2'(j)};
            if (second_reg)
                pad_word[31-8*j -: 8] = 8'h00;
            else if (bidx == fill_reg)
                pad_word[31-8*j -: 8] = 8'h80;
            else if (bidx > fill_reg)
                pad_word[31-8*j -: 8] = 8'h00;
        end
        if (fin_reg && (second_reg || fill_reg < 6'd56))
        begin
            if (cnt_reg[3:0] == 4'd15)
                pad_word = total_reg[63:32];
            else if (cnt_reg[3:0] == 4'd0)
                pad_word = total_reg[31:0];
        end
    end

    assign wr_en   = (state_reg == sha_pkg::ST_IDLE) && in_valid && in_data.has_byte;
    assign wr_addr = fill_reg[5:2];
    assign wr_data = {4{in_data.data_byte}};
    assign rd_addr = cnt_reg[3:0];
    always_comb
    begin
        wr_be = '0;
        wr_be[~fill_reg[1:0]] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int j = 0; j < 4; j++)
                if (wr_be[j])
                    mem[wr_addr][8*j +: 8] <= wr_data[8*j +: 8];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.has_byte && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                    else if (in_data.last)
                        state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD:
                if (cnt_reg == 7'd16)
                    state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
                if (cnt_reg == 7'd63)
                    state_next = sha_pkg::ST_FOLD;
            sha_pkg::ST_FOLD:
                state_next = sha_pkg::ST_PAD;
            sha_pkg::ST_PAD:
            begin
                if (!fin_reg)
                    state_next = tail_reg ? sha_pkg::ST_LOAD : sha_pkg::ST_IDLE;
                else if (!second_reg && fill_reg >= 6'd56)
                    state_next = sha_pkg::ST_LOAD;
                else
                    state_next = sha_pkg::ST_EMIT;
            end
            sha_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready && oidx_reg == 2'd3)
                    state_next = sha_pkg::ST_IDLE;
            end
            default:
                state_next = sha_pkg::ST_IDLE;
        endcase
    end

    assign out_data.digest_word = hash_reg[255 - 64*oidx_reg -: 64];
    assign out_data.word_index  = oidx_reg;
    assign out_data.digest_last = (oidx_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            hash_reg   <= {sha_pkg::INIT_H[0], sha_pkg::INIT_H[1], sha_pkg::INIT_H[2],
                           sha_pkg::INIT_H[3], sha_pkg::INIT_H[4], sha_pkg::INIT_H[5],
                           sha_pkg::INIT_H[6], sha_pkg::INIT_H[7]};
            v_reg      <= '0;
            sched_reg  <= '0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            tail_reg   <= 1'b0;
            oidx_reg   <= '0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                    if (in_valid)
                    begin
                        cnt_reg    <= '0;
                        second_reg <= 1'b0;
                        fin_reg    <= in_data.last && !(in_data.has_byte && fill_reg == 6'd63);
                        if (in_data.has_byte)
                            fill_reg <= fill_reg + 6'd1;
                        if (in_data.has_byte && fill_reg == 6'd63)
                            bits_reg <= bits_reg + 64'd512;
                        total_reg <= bits_reg + {55'd0, fill_reg, 3'd0}
                                     + (in_data.has_byte ? 64'd8 : 64'd0);
                        // a last byte that closes a block: pad in a further pass
                        tail_reg <= in_data.last && in_data.has_byte && fill_reg == 6'd63;
                    end
                sha_pkg::ST_LOAD:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0)
                        sched_reg <= {sched_reg[479:0],
                                      fin_reg ? pad_word : rd_data_reg};
                    if (cnt_reg == 7'd16)
                    begin
                        cnt_reg <= '0;
                        v_reg   <= hash_reg;
                    end
                end
                sha_pkg::ST_ROUND:
                begin
                    v_reg     <= v_new;
                    sched_reg <= {sched_reg[479:0], w_next};
                    cnt_reg   <= cnt_reg + 7'd1;
                end
                sha_pkg::ST_FOLD:
                    for (int j = 0; j < 8; j++)
                        hash_reg[32*j +: 32] <= hash_reg[32*j +: 32] + v_reg[32*j +: 32];
                sha_pkg::ST_PAD:
                begin
                    cnt_reg <= '0;
                    oidx_reg <= '0;
                    if (!fin_reg && tail_reg)
                    begin
                        fin_reg  <= 1'b1;
                        tail_reg <= 1'b0;
                    end
                    if (fin_reg && !second_reg && fill_reg >= 6'd56)
                        second_reg <= 1'b1;
                end
                sha_pkg::ST_EMIT:
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                        begin
                            hash_reg <= {sha_pkg::INIT_H[0], sha_pkg::INIT_H[1],
                                         sha_pkg::INIT_H[2], sha_pkg::INIT_H[3],
                                         sha_pkg::INIT_H[4], sha_pkg::INIT_H[5],
                                         sha_pkg::INIT_H[6], sha_pkg::INIT_H[7]};
                            fill_reg <= '0;
                            bits_reg <= '0;
                        end
                    end
                default:
                    cnt_reg <= '0;
            endcase
        end
    end
endmodule

@@ test/sha256_digest_checker.sv @@
`timescale 1ns / 100ps

module sha256_digest_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  sha_pkg::in_word_t   in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  sha_pkg::out_word_t  out_data,
    output int                  fail_count,
    output int                  pending_count
);
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]        chain [8];
    logic [7:0]         buf_bytes [64];
    logic [5:0]         fill;
    logic [63:0]        bit_total;
    sha_pkg::out_word_t digest_q [$];

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            chain[i] = IV_TAB[i];
        fill = 0;
        bit_total = 0;
    endtask

    task automatic absorb_word(sha_pkg::in_word_t w);
        logic [63:0]        len;
        sha_pkg::out_word_t r;
        if (w.has_byte)
        begin
            buf_bytes[fill] = w.data_byte;
            if (fill == 6'd63)
            begin
                compress_block();
                bit_total += 64'd512;
            end
            fill = fill + 6'd1;
        end
        if (w.last)
        begin
            len = bit_total + {55'd0, fill, 3'd0};
            buf_bytes[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++)
                buf_bytes[i] = 8'h00;
            if (fill >= 6'd56)
            begin
                compress_block();
                for (int i = 0; i < 56; i++)
                    buf_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                buf_bytes[56+i] = len[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 4; i++)
            begin
                r.digest_word = {chain[2*i], chain[2*i+1]};
                r.word_index  = 2'(i);
                r.digest_last = (i == 3);
                digest_q.push_back(r);
            end
            restart_message();
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        restart_message();
    end

    always @(posedge clk)
    begin
        sha_pkg::out_word_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_word(in_data);
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", out_data));
                else
                begin
                    e = digest_q.pop_front();
                    if (out_data.digest_word !== e.digest_word)
                        report_mismatch($sformatf("digest_word %h, want %h",
                            out_data.digest_word, e.digest_word));
                    if (out_data.word_index !== e.word_index)
                        report_mismatch($sformatf("word_index %0d, want %0d",
                            out_data.word_index, e.word_index));
                    if (out_data.digest_last !== e.digest_last)
                        report_mismatch($sformatf("digest_last %b, want %b",
                            out_data.digest_last, e.digest_last));
                end
            end
            pending_count = digest_q.size();
        end
    end
endmodule

@@ test/sha256_byte_stream_hasher_unit_tb.sv @@
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_unit_tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    sha_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    sha_pkg::out_word_t out_data;
    int                 fail_count;
    int                 pending_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_cycles;

    sha256_byte_stream_hasher_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    sha256_digest_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [7:0] b, logic hb, logic lst);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, has_byte: hb, last: lst};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_message(int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_word(8'($urandom), 1'b1, 1'b0);
        send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count > 0)
            @(posedge clk);
    endtask

    int    n;
    int    r;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, one-byte messages at byte extremes, last carrying a byte
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'h3c, 1'b0, 1'b0);
        send_word(8'hc3, 1'b1, 1'b1);
        drain_results();

        // padding boundaries: 55, 56 (spill block), 63, 64 (full block) bytes
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        drain_results();

        // long receiver hold-off while sending stays busy
        hold_cycles = 600;
        for (int m = 0; m < 6; m++)
            send_message($urandom_range(3));
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            n = 0;
            while (n < 36)
            begin
                r = $urandom_range(99);
                if (r < 80)
                begin
                    r = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
                    send_message(r);
                    n += r + 1;
                end
                else
                begin
                    send_word(8'($urandom), 1'($urandom), 1'($urandom));
                    n++;
                end
            end
        end
        send_word(8'($urandom), 1'b0, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (400) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("** sha256_byte_stream_hasher_unit: PASSED **");
        else
            $display("** sha256_byte_stream_hasher_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("** sha256_byte_stream_hasher_unit: FAILED **");
        $finish;
    end
endmodule
